// ----- hw/rtl/srlm_pkg.sv -----
// Shared types, constants and register indexes of the stereo RMS level meter.
package srlm_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int SQUARE_W      = 2 * SAMPLE_BITS - 1;
  localparam int MEAN_W        = 2 * SAMPLE_BITS;
  localparam int ROOT_W        = SAMPLE_BITS;
  localparam int LEVEL_W       = 16;
  localparam int COUNT_W       = 32;
  localparam int DEN_W         = 16;
  localparam int MAX_PAIRS_DEF = 256;

  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

  localparam logic [LEVEL_W-1:0] KEEP_RST       = 16'd60948;
  localparam logic [LEVEL_W-1:0] FULL_SCALE_RST = 16'd11141;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 16'hFFFF;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_SQRT,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_SCALE_START,
    ST_DIV_SCALE,
    ST_OUT
  } srlm_state_e;

endpackage

// ----- hw/rtl/srlm_lane.sv -----
// One channel lane: registered square of a signed sample.
module srlm_lane (
  input  logic                                      clk_i,
  input  logic                                      load_i,
  input  logic signed [srlm_pkg::SAMPLE_BITS-1:0]   sample_i,
  output logic        [srlm_pkg::SQUARE_W-1:0]      square_o
);

  logic signed [2*srlm_pkg::SAMPLE_BITS-1:0] prod;
  logic        [srlm_pkg::SQUARE_W-1:0]      square_q;

  assign prod = sample_i * sample_i;

  // Square of a two's complement value never exceeds 2^(2N-2): top bit drops.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      square_q <= prod[srlm_pkg::SQUARE_W-1:0];
    end
  end

  assign square_o = square_q;

endmodule

// ----- hw/rtl/srlm_accum.sv -----
// Merge stage: adds both lane squares into the running buffer sum.
module srlm_accum #(
  parameter int SUM_W = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srlm_pkg::acc_ctrl_t               ctrl_i,
  input  logic [srlm_pkg::SQUARE_W-1:0]     square_l_i,
  input  logic [srlm_pkg::SQUARE_W-1:0]     square_r_i,
  output logic [SUM_W-1:0]                  sum_o
);

  logic [srlm_pkg::SQUARE_W:0] pair_sum;
  logic [SUM_W-1:0]            sum_q, sum_d, sum_next;

  assign pair_sum = {1'b0, square_l_i} + {1'b0, square_r_i};
  assign sum_next = ctrl_i.add ? sum_q + SUM_W'(pair_sum) : sum_q;
  assign sum_d    = ctrl_i.clear ? '0 : sum_next;
  assign sum_o    = sum_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

// ----- hw/rtl/srlm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module srlm_div #(
  parameter int NUM_W = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [NUM_W-1:0]               num_i,
  input  logic [srlm_pkg::DEN_W-1:0]     den_i,
  output logic                           done_o,
  output logic [NUM_W-1:0]               quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]             num_q, num_d;
  logic [srlm_pkg::DEN_W-1:0]   den_q, rem_q, rem_d;
  logic [srlm_pkg::DEN_W:0]     shifted, diff;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         busy_q, busy_d, done_q, done_d;
  logic                         ge;

  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift the quotient bit in where the numerator bit leaves.
      num_d = {num_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[srlm_pkg::DEN_W-1:0] : shifted[srlm_pkg::DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ----- hw/rtl/srlm_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
module srlm_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [srlm_pkg::MEAN_W-1:0]     rad_i,
  output logic                            done_o,
  output logic [srlm_pkg::ROOT_W-1:0]     root_o
);

  localparam int RW    = srlm_pkg::ROOT_W;
  localparam int REM_W = RW + 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [srlm_pkg::MEAN_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic [RW-1:0]               root_q, root_d;
  logic [REM_W+1:0]            rem_sh, trial, diff;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic                        ge;

  assign rem_sh = {rem_q, rad_q[srlm_pkg::MEAN_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(RW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[srlm_pkg::MEAN_W-3:0], 2'b00};
      rem_d  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_d = {root_q[RW-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/stereo_rms_level_meter.sv -----
// Top level of the stereo RMS level meter: lanes, merge, end-of-buffer sequencer.
//
// Usage:
//   Sample pairs enter on the s_axis channel, one item per stereo pair; tlast
//   closes a buffer. While meter_enable is low every item is taken and dropped.
//   Each accepted pair is squared in two parallel lanes (left, right) and the
//   merge stage adds both squares into the buffer sum, one pair per cycle.
//   Pairs past MAX_PAIRS add nothing, but their tlast still closes the buffer.
//   When a buffer closes, the sequencer runs the shared divider (mean square),
//   the square root unit, the smoothing filter's multiply states (MUL_OLD,
//   MUL_NEW) and the divider again for the full-scale ratio, then emits one
//   result item on m_axis. The sum and the divider numerator are SUM_W =
//   32 + log2(MAX_PAIRS) bits wide. s_axis_tready stays low during that math,
//   so within a buffer the rate is one pair per cycle.
//   A finished result waits in the output register; a stalled receiver holds
//   m_axis and the next buffer keeps filling until its own close.
//   Reset clears the sum, the count, the smoothed level, the buffer counter and
//   restores the register defaults (meter disabled). cfg_ready_o is always high.
module stereo_rms_level_meter #(
  parameter int MAX_PAIRS = srlm_pkg::MAX_PAIRS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [srlm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [srlm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Sample pair stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,  // left_sample, right_sample
  input  logic                                s_axis_tlast,  // last_in_buffer
  // Level result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [79:0]                         m_axis_tdata   // rms, smoothed, scaled, count
);

  localparam int SB     = srlm_pkg::SAMPLE_BITS;
  localparam int LW     = srlm_pkg::LEVEL_W;
  localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
  localparam int SUM_W  = 2 * SB + $clog2(MAX_PAIRS);

  // Configuration registers
  logic          enable_q;
  logic [LW-1:0] keep_q;
  logic [LW-1:0] full_scale_q;

  // Control
  srlm_pkg::srlm_state_e state_q, state_d;
  logic [CNT_W-1:0]      pair_cnt_q, pair_cnt_d;
  logic                  sq_valid_q, sq_valid_d;
  logic                  close_q, close_d;
  logic                  in_accept, counted;

  // Datapath
  logic [SB*2-2:0]       square_l, square_r;
  srlm_pkg::acc_ctrl_t   acc_ctrl;
  logic [SUM_W-1:0]      sum_next;
  logic                  div_start, div_done;
  logic [SUM_W-1:0]      div_num, div_quo;
  logic [srlm_pkg::DEN_W-1:0] div_den;
  logic                  sqrt_start, sqrt_done;
  logic [srlm_pkg::ROOT_W-1:0] root;

  logic [LW-1:0]         rms_q, smooth_q, scaled_q;
  logic [2*LW-1:0]       prod_q;
  logic [LW:0]           new_weight;
  logic [2*LW:0]         acc_sum;
  logic [2*LW-1:0]       scale_num;
  logic [srlm_pkg::COUNT_W-1:0] buffers_q;

  logic                  out_load, m_valid_q;
  logic [79:0]           m_data_q;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, writes beyond the register list are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      keep_q       <= srlm_pkg::KEEP_RST;
      full_scale_q <= srlm_pkg::FULL_SCALE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srlm_pkg::CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        srlm_pkg::CFG_KEEP:       keep_q       <= cfg_data_i;
        srlm_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: take pairs only in idle and not in the cycle that closes a buffer.
  assign s_axis_tready = (state_q == srlm_pkg::ST_IDLE) && !close_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready && enable_q;
  assign counted       = in_accept && (pair_cnt_q < CNT_W'(MAX_PAIRS));

  srlm_lane u_lane_left (
    .clk_i    (clk_i),
    .load_i   (counted),
    .sample_i (s_axis_tdata[SB-1:0]),
    .square_o (square_l)
  );

  srlm_lane u_lane_right (
    .clk_i    (clk_i),
    .load_i   (counted),
    .sample_i (s_axis_tdata[16 +: SB]),
    .square_o (square_r)
  );

  // Merge a lane pair in the cycle after it was squared; on close, hand the full
  // sum to the divider and clear for the next buffer.
  assign acc_ctrl.add   = sq_valid_q;
  assign acc_ctrl.clear = close_q;

  srlm_accum #(
    .SUM_W (SUM_W)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .square_l_i (square_l),
    .square_r_i (square_r),
    .sum_o      (sum_next)
  );

  // ---------------------------------------------------------------------------
  // Shared divider: mean square first, full-scale ratio second.
  assign scale_num = {smooth_q, {LW{1'b0}}} - (2*LW)'(smooth_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = SUM_W'(scale_num);
    div_den   = full_scale_q;
    if (state_q == srlm_pkg::ST_IDLE) begin
      div_start = close_q;
      div_num   = sum_next;
      div_den   = srlm_pkg::DEN_W'({pair_cnt_q, 1'b0});
    end else if (state_q == srlm_pkg::ST_SCALE_START) begin
      div_start = 1'b1;
    end
  end

  srlm_div #(
    .NUM_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign sqrt_start = (state_q == srlm_pkg::ST_DIV_MEAN) && div_done;

  // Mean of the squared samples is at most 2^30, so the low word holds it.
  srlm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_quo[srlm_pkg::MEAN_W-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  assign out_load = (state_q == srlm_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    pair_cnt_d = pair_cnt_q;
    sq_valid_d = counted;
    close_d    = in_accept && s_axis_tlast;
    if (counted) begin
      pair_cnt_d = pair_cnt_q + CNT_W'(1);
    end
    unique case (state_q)
      srlm_pkg::ST_IDLE: begin
        if (close_q) begin
          pair_cnt_d = '0;
          state_d    = srlm_pkg::ST_DIV_MEAN;
        end
      end
      srlm_pkg::ST_DIV_MEAN: begin
        if (div_done) begin
          state_d = srlm_pkg::ST_SQRT;
        end
      end
      srlm_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_d = srlm_pkg::ST_MUL_OLD;
        end
      end
      srlm_pkg::ST_MUL_OLD:     state_d = srlm_pkg::ST_MUL_NEW;
      srlm_pkg::ST_MUL_NEW:     state_d = srlm_pkg::ST_SCALE_START;
      srlm_pkg::ST_SCALE_START: state_d = srlm_pkg::ST_DIV_SCALE;
      srlm_pkg::ST_DIV_SCALE: begin
        if (div_done) begin
          state_d = srlm_pkg::ST_OUT;
        end
      end
      srlm_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = srlm_pkg::ST_IDLE;
        end
      end
      default: state_d = srlm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= srlm_pkg::ST_IDLE;
      pair_cnt_q <= '0;
      sq_valid_q <= 1'b0;
      close_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      pair_cnt_q <= pair_cnt_d;
      sq_valid_q <= sq_valid_d;
      close_q    <= close_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Smoothing filter: keep*old in ST_MUL_OLD, then add (1 - keep)*rms in ST_MUL_NEW.
  assign new_weight = (LW + 1)'(1 << LW) - (LW + 1)'(keep_q);
  assign acc_sum    = (2*LW + 1)'(prod_q) +
                      (2*LW + 1)'(new_weight) * (2*LW + 1)'(rms_q);

  always_ff @(posedge clk_i) begin
    if ((state_q == srlm_pkg::ST_SQRT) && sqrt_done) begin
      rms_q <= root;
    end
    if (state_q == srlm_pkg::ST_MUL_OLD) begin
      prod_q <= keep_q * smooth_q;
    end
    if ((state_q == srlm_pkg::ST_DIV_SCALE) && div_done) begin
      // Clamp the ratio at one; a zero full scale divides to all ones.
      scaled_q <= (|div_quo[SUM_W-1:LW]) ? srlm_pkg::LEVEL_MAX : div_quo[LW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q  <= '0;
      buffers_q <= '0;
    end else begin
      if (state_q == srlm_pkg::ST_MUL_NEW) begin
        smooth_q <= acc_sum[2*LW-1:LW];
      end
      if (out_load) begin
        buffers_q <= buffers_q + srlm_pkg::COUNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the item until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {buffers_q + srlm_pkg::COUNT_W'(1), scaled_q, smooth_q, rms_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
